FILE: rtl/cfmm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfmm_pkg
// shared types, codes and widths of the crossfade matrix mixer
// ----------------------------------------------------------------------------
package cfmm_pkg;

  localparam int MAX_CHANNELS_DEF = 16;
  localparam int SAMPLE_BITS      = 16;
  localparam int GAIN_W           = 17;
  localparam int CUR_W            = 33;
  localparam int STEP_W           = 34;
  localparam int ACC_W            = 48;
  localparam int TOT_W            = 32;
  localparam int DIV_N            = 34;
  localparam int IN_TDATA_W       = 48;
  localparam int OUT_TDATA_W      = 40;

  localparam logic [GAIN_W-1:0] UNITY_Q16   = 17'd65536;
  localparam logic [4:0]        RST_CHANNELS = 5'd2;
  localparam logic [15:0]       RST_RAMP     = 16'd4410;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;

  localparam logic REG_CHANNELS = 1'b0;
  localparam logic REG_RAMP     = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CRD,
    ST_CLD,
    ST_CDIV,
    ST_SAMPLE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [STEP_W-1:0] step;
    logic [GAIN_W-1:0]        target;
    logic [CUR_W-1:0]         cur;
  } gain_word_t;

endpackage
`default_nettype wire

FILE: rtl/cfmm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfmm_ram
// generic one-write one-read ram with registered read data
// ----------------------------------------------------------------------------
module cfmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: rtl/cfmm_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfmm_div
// restoring divider, one quotient bit per cycle, for the ramp step
// ----------------------------------------------------------------------------
module cfmm_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [cfmm_pkg::DIV_N-1:0]    dividend,
  input  wire logic [15:0]                   divisor,
  output logic                               done,
  output logic      [cfmm_pkg::DIV_N-1:0]    quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic [16:0] sh;

  assign sh = {rem, quotient[cfmm_pkg::DIV_N-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quotient <= dividend;
        dsr      <= divisor;
        rem      <= '0;
        cnt      <= '0;
        busy     <= 1'b1;
      end else if (busy) begin
        if (sh >= {1'b0, dsr}) begin
          rem      <= 16'(sh - {1'b0, dsr});
          quotient <= {quotient[cfmm_pkg::DIV_N-2:0], 1'b1};
        end else begin
          rem      <= sh[15:0];
          quotient <= {quotient[cfmm_pkg::DIV_N-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(cfmm_pkg::DIV_N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/crossfade_matrix_mixer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crossfade_matrix_mixer_unit
// square crosspoint mixer with per-cell gain ramps and mix-minus outputs
// ----------------------------------------------------------------------------
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata: opcode, row, column, sample, gain
// m_      | out | m_tvalid/m_tready  | m_tdata: channel, matrix, mix-minus; tlast
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// a sample item, with n = channels in use, makes one gain ram
// access per column through a four-stage read/update/multiply/add pipe.
// a frame end sends n items, one per cycle while m_tready holds high.
// a commit sweeps all MAX_CHANNELS^2 cells, bound by the bit-serial step
// divider; a write item goes straight to the pending gain ram.
// after reset a clearing pass over all MAX_CHANNELS^2 cells fills both rams;
// s_tready stays low during it and during any commit, sample or frame end.
// ----------------------------------------------------------------------------
module crossfade_matrix_mixer_unit #(
  parameter int MAX_CHANNELS = cfmm_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // opcode[1:0], row_channel[5:2], column_channel[9:6],
  // sample_value[25:10], gain_value[42:26], zero[47:43]
  input  wire logic [cfmm_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // out_channel[3:0], matrix_sample[19:4], mix_minus_sample[35:20], zero[39:36]
  output logic      [cfmm_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic                                    m_tlast,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic                               cfg_index,
  input  wire logic [15:0]                        cfg_data
);

  localparam int CELLS = MAX_CHANNELS * MAX_CHANNELS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RST_N = (MAX_CHANNELS < 2) ? MAX_CHANNELS : 2;

  function automatic logic [AW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
    return AW'(int'(r) * MAX_CHANNELS + int'(c));
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [cfmm_pkg::ACC_W-1:0] v);
    if (v > 48'sd32767) begin
      return 16'sh7fff;
    end else if (v < -48'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  // input fields
  logic [1:0]         in_op;
  logic [3:0]         in_row;
  logic [3:0]         in_col;
  logic signed [15:0] in_sample;
  logic [16:0]        in_gain;
  logic [16:0]        in_gain_sat;

  assign in_op       = s_tdata[1:0];
  assign in_row      = s_tdata[5:2];
  assign in_col      = s_tdata[9:6];
  assign in_sample   = s_tdata[25:10];
  assign in_gain     = s_tdata[42:26];
  assign in_gain_sat = (in_gain > cfmm_pkg::UNITY_Q16) ? cfmm_pkg::UNITY_Q16 : in_gain;

  cfmm_pkg::state_t state, state_next;

  logic [4:0]  cfg_chan;
  logic [15:0] cfg_ramp;
  logic [4:0]  n_eff;
  logic [CW-1:0] last_c;
  logic [15:0] ramp_eff;

  assign n_eff = (cfg_chan == 5'd0) ? 5'd1 :
                 (cfg_chan > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : cfg_chan;
  assign last_c   = CW'(n_eff - 5'd1);
  assign ramp_eff = (cfg_ramp == 16'd0) ? 16'd1 : cfg_ramp;

  logic          commit_waiting;
  logic          ret_sample;
  logic [AW-1:0] k;
  logic          k_last;
  logic [3:0]    item_row;
  logic signed [15:0] item_s;
  logic          row_ok;

  assign k_last = (k == AW'(CELLS - 1));

  // sample pipeline
  logic          issuing;
  logic [CW-1:0] issue_c;
  logic          v1, v2, v3;
  logic [CW-1:0] c1, c2, c3;
  logic [16:0]   gn2;
  logic signed [33:0] prod3;
  logic          pipe_done;

  logic signed [cfmm_pkg::ACC_W-1:0] acc [MAX_CHANNELS];
  logic signed [15:0]                fs  [MAX_CHANNELS];
  logic signed [cfmm_pkg::TOT_W-1:0] total;
  logic [CW-1:0] oc;
  logic          out_load;

  // commit hold registers
  logic [cfmm_pkg::CUR_W-1:0] cur_h;
  logic [16:0]               tgt_h;
  logic                      neg_h;
  logic [33:0]               mag_h;

  logic in_acc;
  assign s_tready  = (state == cfmm_pkg::ST_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  // ram ports
  logic                   g_we;
  logic [AW-1:0]          g_waddr, g_raddr;
  cfmm_pkg::gain_word_t   g_wdata, g_rd;
  logic                   p_we;
  logic [AW-1:0]          p_waddr;
  logic [16:0]            p_wdata, p_rd;

  cfmm_ram #(.WIDTH($bits(cfmm_pkg::gain_word_t)), .DEPTH(CELLS)) u_gain_ram (
    .clk  (clk),
    .we   (g_we),
    .waddr(g_waddr),
    .wdata(g_wdata),
    .raddr(g_raddr),
    .rdata(g_rd)
  );

  cfmm_ram #(.WIDTH(cfmm_pkg::GAIN_W), .DEPTH(CELLS)) u_pend_ram (
    .clk  (clk),
    .we   (p_we),
    .waddr(p_waddr),
    .wdata(p_wdata),
    .raddr(k),
    .rdata(p_rd)
  );

  // step divider
  logic        div_start, div_done;
  logic [33:0] div_q;
  logic signed [34:0] cdiff;
  logic        cneg;
  logic [33:0] cmag;

  assign cdiff = $signed({2'b00, p_rd, 16'd0}) - $signed({2'b00, g_rd.cur});
  assign cneg  = cdiff[34];
  assign cmag  = cneg ? 34'(-cdiff) : cdiff[33:0];

  cfmm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(cmag),
    .divisor (ramp_eff),
    .done    (div_done),
    .quotient(div_q)
  );

  logic [33:0]        q_fix;
  logic signed [33:0] step_new;
  assign q_fix    = (div_q == 34'd0 && mag_h != 34'd0) ? 34'd1 : div_q;
  assign step_new = neg_h ? -$signed(q_fix) : $signed(q_fix);

  // gain update for the cell read in the cycle before
  logic [32:0]        t33;
  logic signed [34:0] gs, t35, g_sn;
  logic               snap, changed;
  logic [32:0]        gnew;

  always_comb begin
    t33     = {g_rd.target, 16'd0};
    t35     = $signed({2'b00, t33});
    changed = (g_rd.cur != t33);
    gs      = $signed({2'b00, g_rd.cur}) + 35'(g_rd.step);
    snap    = g_rd.step[33] ? (gs < t35) : (gs > t35);
    g_sn    = snap ? t35 : gs;
    if (g_sn < 35'sd0) begin
      g_sn = 35'sd0;
    end else if (g_sn > 35'sd4294967296) begin
      g_sn = 35'sd4294967296;
    end
    gnew = changed ? g_sn[32:0] : g_rd.cur;
  end

  // ring pattern of the pending gains at reset size: cells (1,0) and (0,1)
  logic          ring_cell;
  assign ring_cell = (RST_N == 1) ? (k == '0) :
                     ((k == AW'(1)) || (k == AW'(MAX_CHANNELS)));

  assign pipe_done = !issuing && !v1 && !v2 && !v3;
  assign out_load  = (state == cfmm_pkg::ST_OUT) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    g_we       = 1'b0;
    g_waddr    = k;
    g_wdata    = '0;
    g_raddr    = (state == cfmm_pkg::ST_SAMPLE) ? cell_addr(item_row, 4'(issue_c)) : k;
    p_we       = 1'b0;
    p_waddr    = k;
    p_wdata    = ring_cell ? cfmm_pkg::UNITY_Q16 : 17'd0;
    case (state)
      cfmm_pkg::ST_CLEAR: begin
        g_we = 1'b1;
        p_we = 1'b1;
        if (k_last) state_next = cfmm_pkg::ST_IDLE;
      end
      cfmm_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_op)
            cfmm_pkg::OP_WRITE: begin
              p_waddr = cell_addr(in_row, in_col);
              p_wdata = in_gain_sat;
              p_we    = ({1'b0, in_row} < n_eff) && ({1'b0, in_col} < n_eff);
            end
            cfmm_pkg::OP_COMMIT: state_next = cfmm_pkg::ST_CRD;
            cfmm_pkg::OP_SAMPLE: begin
              if (commit_waiting) state_next = cfmm_pkg::ST_CRD;
              else if ({1'b0, in_row} < n_eff) state_next = cfmm_pkg::ST_SAMPLE;
            end
            default: ;
          endcase
        end
      end
      cfmm_pkg::ST_CRD: state_next = cfmm_pkg::ST_CLD;
      cfmm_pkg::ST_CLD: begin
        div_start  = 1'b1;
        state_next = cfmm_pkg::ST_CDIV;
      end
      cfmm_pkg::ST_CDIV: begin
        if (div_done) begin
          g_we    = 1'b1;
          g_wdata = '{step: step_new, target: tgt_h, cur: cur_h};
          if (!k_last) state_next = cfmm_pkg::ST_CRD;
          else if (ret_sample && row_ok) state_next = cfmm_pkg::ST_SAMPLE;
          else state_next = cfmm_pkg::ST_IDLE;
        end
      end
      cfmm_pkg::ST_SAMPLE: begin
        g_waddr = cell_addr(item_row, 4'(c1));
        g_wdata = '{step: g_rd.step, target: g_rd.target, cur: gnew};
        g_we    = v1 && changed;
        if (pipe_done) begin
          state_next = ({1'b0, item_row} == n_eff - 5'd1) ? cfmm_pkg::ST_OUT
                                                          : cfmm_pkg::ST_IDLE;
        end
      end
      cfmm_pkg::ST_OUT: begin
        if (out_load && oc == last_c) state_next = cfmm_pkg::ST_IDLE;
      end
      default: state_next = cfmm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfmm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // output values for column oc
  logic signed [cfmm_pkg::ACC_W-1:0] rnd;
  logic signed [cfmm_pkg::ACC_W-1:0] mm48;
  assign rnd  = (acc[oc] + 48'sd32768) >>> 16;
  assign mm48 = 48'(total) - 48'(fs[oc]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_chan       <= cfmm_pkg::RST_CHANNELS;
      cfg_ramp       <= cfmm_pkg::RST_RAMP;
      commit_waiting <= 1'b1;
      ret_sample     <= 1'b0;
      k              <= '0;
      issuing        <= 1'b0;
      v1             <= 1'b0;
      v2             <= 1'b0;
      v3             <= 1'b0;
      m_tvalid       <= 1'b0;
      total          <= '0;
      oc             <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        acc[i] <= '0;
        fs[i]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == cfmm_pkg::REG_CHANNELS) cfg_chan <= cfg_data[4:0];
        else cfg_ramp <= cfg_data;
      end

      if (state == cfmm_pkg::ST_CLEAR) k <= k_last ? '0 : k + AW'(1);

      if (in_acc && in_op == cfmm_pkg::OP_SAMPLE) begin
        item_row   <= in_row;
        item_s     <= in_sample;
        row_ok     <= ({1'b0, in_row} < n_eff);
        ret_sample <= 1'b1;
      end else if (in_acc && in_op == cfmm_pkg::OP_COMMIT) begin
        ret_sample <= 1'b0;
      end

      if (state == cfmm_pkg::ST_CLD) begin
        cur_h <= g_rd.cur;
        tgt_h <= p_rd;
        neg_h <= cneg;
        mag_h <= cmag;
      end
      if (state == cfmm_pkg::ST_CDIV && div_done) begin
        if (k_last) begin
          k              <= '0;
          commit_waiting <= 1'b0;
        end else begin
          k <= k + AW'(1);
        end
      end

      // sample pipe: issue, update, multiply, accumulate
      if (state_next == cfmm_pkg::ST_SAMPLE && state != cfmm_pkg::ST_SAMPLE) begin
        issuing <= 1'b1;
        issue_c <= '0;
      end else if (issuing) begin
        if (issue_c == last_c) issuing <= 1'b0;
        issue_c <= issue_c + CW'(1);
      end
      v1  <= issuing;
      c1  <= issue_c;
      v2  <= v1;
      c2  <= c1;
      gn2 <= gnew[32:16];
      v3  <= v2;
      c3  <= c2;
      prod3 <= item_s * $signed({1'b0, gn2});
      if (v3) acc[c3] <= acc[c3] + 48'(prod3);

      if (state == cfmm_pkg::ST_SAMPLE && pipe_done) begin
        fs[item_row[CW-1:0]] <= item_s;
        total                <= total + 32'(item_s);
        oc                   <= '0;
      end

      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {4'd0, sat16(mm48), sat16(rnd), 4'(oc)};
        m_tlast  <= (oc == last_c);
        if (oc == last_c) begin
          total <= '0;
          for (int i = 0; i < MAX_CHANNELS; i++) begin
            acc[i] <= '0;
            fs[i]  <= '0;
          end
        end else begin
          oc <= oc + CW'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cfmm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfmm_checker
// port-level checks of the crossfade matrix mixer
// ----------------------------------------------------------------------------
module cfmm_checker (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tready,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [cfmm_pkg::OUT_TDATA_W-1:0] m_tdata,
  input wire logic                             m_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output item changed");

  // frame results follow without gaps
  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("gap inside frame output");

  // no new input while a frame is still going out
  a_no_in_mid_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input taken during frame output");

  // clearing pass starts right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid && !s_tready)
    else $error("activity right after reset");

endmodule

bind crossfade_matrix_mixer_unit cfmm_checker u_cfmm_checker (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata),
  .m_tlast (m_tlast)
);
`default_nettype wire

FILE: sim/cfmm_mix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfmm_mix_checker
// watches the item, config and result channels of the crossfade mixer,
// keeps its own gain ramp and mixing state and compares every result item
// ----------------------------------------------------------------------------
module cfmm_mix_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [47:0] s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [39:0] m_tdata,
  input  wire logic        m_tlast,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  output int               fail_count,
  output int               mixes_waiting,
  output int               mixes_seen,
  output int               items_seen,
  output int               commits_seen
);
  import cfmm_pkg::*;

  localparam int NCH = 16;
  localparam longint UNITY_CUR = 64'sd1 << 32;

  typedef struct packed {
    logic [3:0]  ch;
    logic [15:0] matrix;
    logic [15:0] mixminus;
    logic        last;
  } mix_out_t;

  mix_out_t mix_q[$];

  logic [4:0]  size_reg;
  logic [15:0] ramp_reg;
  longint cur_gain [NCH*NCH];
  longint tgt_gain [NCH*NCH];
  longint gstep    [NCH*NCH];
  longint pend_gain[NCH*NCH];
  bit     commit_pending;
  longint col_acc  [NCH];
  longint chan_smp [NCH];
  longint smp_total;

  assign mixes_waiting = mix_q.size();

  function automatic int active_size();
    if (size_reg < 1) return 1;
    if (size_reg > NCH) return NCH;
    return size_reg;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  task automatic commit_gains();
    longint ramp, diff, mag, q;
    ramp = (ramp_reg == 0) ? 1 : ramp_reg;
    for (int k = 0; k < NCH*NCH; k++) begin
      tgt_gain[k] = pend_gain[k];
      diff = (tgt_gain[k] <<< 16) - cur_gain[k];
      mag = (diff < 0) ? -diff : diff;
      q = mag / ramp;
      if (q == 0 && mag != 0) q = 1;
      gstep[k] = (diff < 0) ? -q : q;
    end
    commit_pending = 0;
    commits_seen++;
  endtask

  task automatic clear_frame();
    for (int c = 0; c < NCH; c++) begin
      col_acc[c] = 0;
      chan_smp[c] = 0;
    end
    smp_total = 0;
  endtask

  task automatic mix_item(logic [47:0] d);
    logic [1:0] op;
    int row, col, n, k;
    longint s, g, t, st, gv;
    mix_out_t o;
    op  = d[1:0];
    row = d[5:2];
    col = d[9:6];
    s   = $signed(d[25:10]);
    gv  = d[42:26];
    n   = active_size();
    if (op == OP_WRITE) begin
      if (gv > 65536) gv = 65536;
      if (row < n && col < n) pend_gain[row*NCH + col] = gv;
    end else if (op == OP_COMMIT) begin
      commit_gains();
    end else if (op == OP_SAMPLE) begin
      if (commit_pending) commit_gains();
      if (row < n) begin
        for (int c = 0; c < n; c++) begin
          k  = row*NCH + c;
          g  = cur_gain[k];
          t  = tgt_gain[k] <<< 16;
          st = gstep[k];
          if (g != t) begin
            g += st;
            if ((st < 0) ? (g < t) : (g > t)) g = t;
            if (g < 0) g = 0;
            if (g > UNITY_CUR) g = UNITY_CUR;
            cur_gain[k] = g;
          end
          col_acc[c] += s * (g >>> 16);
        end
        chan_smp[row] = s;
        smp_total += s;
        if (row == n - 1) begin
          for (int c = 0; c < n; c++) begin
            o.ch       = c[3:0];
            o.matrix   = clip16((col_acc[c] + 32768) >>> 16);
            o.mixminus = clip16(smp_total - chan_smp[c]);
            o.last     = (c == n - 1);
            mix_q.push_back(o);
          end
          clear_frame();
        end
      end
    end
  endtask

  task automatic report(string what, logic [15:0] exp_v, logic [15:0] act_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %h actual %h at %0t", what, exp_v, act_v, $realtime);
  endtask

  always @(posedge clk) begin
    mix_out_t e;
    if (rst) begin
      size_reg = RST_CHANNELS;
      ramp_reg = RST_RAMP;
      for (int k = 0; k < NCH*NCH; k++) begin
        cur_gain[k] = 0;
        tgt_gain[k] = 0;
        gstep[k] = 0;
        pend_gain[k] = 0;
      end
      // ring pattern for the reset size of two
      pend_gain[1*NCH + 0] = 65536;
      pend_gain[0*NCH + 1] = 65536;
      commit_pending = 1;
      clear_frame();
      mix_q.delete();
      fail_count = 0;
      mixes_seen = 0;
      items_seen = 0;
      commits_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CHANNELS) size_reg = cfg_data[4:0];
        else ramp_reg = cfg_data;
      end
      if (m_tvalid && m_tready) begin
        mixes_seen++;
        if (mix_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result item %h at %0t", m_tdata, $realtime);
        end else begin
          e = mix_q.pop_front();
          if (m_tdata[3:0] != e.ch) report("channel", e.ch, m_tdata[3:0]);
          if (m_tdata[19:4] != e.matrix) report("matrix", e.matrix, m_tdata[19:4]);
          if (m_tdata[35:20] != e.mixminus) report("mix-minus", e.mixminus, m_tdata[35:20]);
          if (m_tlast != e.last) report("tlast", e.last, m_tlast);
        end
      end
      if (s_tvalid && s_tready) begin
        items_seen++;
        mix_item(s_tdata);
      end
    end
  end
endmodule

FILE: sim/tb_crossfade_matrix_mixer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_crossfade_matrix_mixer_unit
// drives sample, gain write and commit items through the mixer over several
// sizes and ramp lengths, with random stalls on both sides; a checker
// beside the block predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_crossfade_matrix_mixer_unit;
  import cfmm_pkg::*;

  localparam int STALL_LIMIT = 40000;
  localparam int COMMIT_DRAIN = 10300;
  // opcode with no meaning, the block drops it
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = REG_CHANNELS;
  logic [15:0] cfg_data = '0;

  int fail_count, mixes_waiting, mixes_seen, items_seen, commits_seen;
  bit idle_en = 1;
  bit hold_req = 0;
  bit hold_done = 0;
  int hold_left = 0;
  int rdy_gap = 0;
  int stall_cnt = 0;
  int cur_n = 2;

  always #2 clk = ~clk;

  crossfade_matrix_mixer_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  cfmm_mix_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .mixes_waiting(mixes_waiting), .mixes_seen(mixes_seen),
    .items_seen(items_seen), .commits_seen(commits_seen)
  );

  // result side: short random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 400;
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 0;
    end else if (rdy_gap > 0) begin
      rdy_gap--;
      m_tready <= 0;
    end else begin
      m_tready <= 1;
      if (idle_en && $urandom_range(0, 7) == 0) rdy_gap = $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("crossfade_matrix_mixer_unit verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [3:0] row, logic [3:0] col,
                           logic [15:0] smp, logic [16:0] gain);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {5'b0, gain, smp, col, row, op};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic send_sample(int row, logic [15:0] smp);
    send_item(OP_SAMPLE, row[3:0], 4'($urandom), smp, 17'($urandom));
  endtask

  task automatic send_gain(int row, int col, logic [16:0] gain);
    send_item(OP_WRITE, row[3:0], col[3:0], 16'($urandom), gain);
  endtask

  task automatic send_commit();
    send_item(OP_COMMIT, 4'($urandom), 4'($urandom), 16'($urandom), 17'($urandom));
  endtask

  task automatic cfg_write(logic idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  // change size and ramp once the block has gone quiet
  task automatic reconfigure(logic [15:0] size_val, logic [15:0] ramp_val);
    s_tvalid <= 0;
    while (mixes_waiting != 0) @(posedge clk);
    repeat (COMMIT_DRAIN) @(posedge clk);
    cfg_write(REG_CHANNELS, size_val);
    cfg_write(REG_RAMP, ramp_val);
    cfg_valid <= 0;
    cur_n = (size_val[4:0] < 1) ? 1 : (size_val[4:0] > 16) ? 16 : size_val[4:0];
  endtask

  function automatic logic [16:0] pick_gain();
    case ($urandom_range(0, 4))
      0: return 17'd65536;
      1: return 17'd0;
      2: return 17'($urandom);
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one mostly well-formed frame with gain writes, rare commits and noise
  task automatic random_frame(int n);
    int r;
    r = 0;
    while (r < n) begin
      case ($urandom_range(0, 39))
        0, 1, 2, 3: send_gain($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_gain());
        4: send_gain($urandom, $urandom, pick_gain());
        5: if ($urandom_range(0, 2) == 0) send_commit();
        6: send_item(OP_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom), 17'($urandom));
        7: send_sample($urandom, pick_sample());
        8: send_sample($urandom_range(0, n - 1), pick_sample());
        9: r++;
        default: begin
          send_sample(r, pick_sample());
          r++;
        end
      endcase
    end
  endtask

  task automatic random_phase(int items);
    int start;
    start = items_seen;
    while (items_seen - start < items) random_frame(cur_n);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;

    // reset settings: first sample commits the ring pattern
    send_sample(0, 16'h7fff);
    send_sample(1, 16'h8000);
    send_sample(5, 16'h1234);
    send_item(OP_UNUSED, 4'hf, 4'hf, 16'hffff, 17'h1ffff);
    send_sample(0, 16'h8000);
    send_sample(1, 16'h8000);

    reconfigure(16'd4, 16'd1);
    send_gain(0, 0, 17'd65536);
    send_gain(1, 0, 17'h1ffff);
    send_gain(2, 3, 17'd0);
    send_gain(3, 3, 17'd32768);
    send_gain(7, 2, 17'd65536);
    send_gain(2, 9, 17'd65536);
    send_commit();
    for (int r = 0; r < 4; r++) send_sample(r, 16'h7fff);
    send_sample(0, 16'h8000);
    send_sample(0, 16'h8000);
    send_sample(3, 16'h0001);
    send_sample(0, 16'h4000);
    send_gain(2, 1, 17'd65536);
    send_commit();
    send_sample(2, 16'hc000);
    send_sample(3, 16'h0100);

    reconfigure(16'd0, 16'd0);
    send_sample(0, 16'h7fff);
    send_sample(0, 16'h8000);

    reconfigure(16'hffff, 16'd65535);
    send_commit();
    for (int r = 0; r < 16; r++) send_sample(r, pick_sample());

    // random phases over several sizes and ramps
    reconfigure(16'd3, 16'd1);
    hold_req = 1;
    random_phase(80);
    s_tvalid <= 0;
    while (mixes_waiting != 0) @(posedge clk);
    random_phase(20);
    reconfigure(16'd16, 16'd2);
    random_phase(100);
    reconfigure(16'd1, 16'd0);
    random_phase(50);
    reconfigure(16'd5, 16'($urandom_range(1, 30)));
    random_phase(80);
    reconfigure(16'd31, 16'd65535);
    random_phase(30);
    idle_en = 0;
    reconfigure(16'd6, 16'd3);
    random_phase(50);

    s_tvalid <= 0;
    while (mixes_waiting != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("run: %0d input items, %0d result items, %0d commits", items_seen,
             mixes_seen, commits_seen);
    $display("sizes 1 to 16 and ramps 0 to 65535, with stalls and a long hold-off");
    if (fail_count == 0 && mixes_waiting == 0) begin
      $display("crossfade_matrix_mixer_unit verification clean");
    end else begin
      $display("crossfade_matrix_mixer_unit verification failed");
    end
    $finish;
  end
endmodule
